>>> hdl/prescaled_down_timer_core_assert.svh
// Assertion macros for the prescaled down timer RTL.
// Depends on nothing; included by pdt_state, the module that carries checks.
`ifndef PRESCALED_DOWN_TIMER_CORE_ASSERT_SVH
`define PRESCALED_DOWN_TIMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pdt assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define PDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pdt assertion failed (next cycle)");

`endif

>>> hdl/pdt_pkg.sv
// Types, constants and helpers for the prescaled down timer.
// No dependencies; used by every pdt module.
`default_nettype none

package pdt_pkg;

	localparam int unsigned CountW = 16;
	localparam int unsigned FlagW  = 8;
	localparam int unsigned DivW   = 7;

	typedef enum logic [1:0] {
		CMD_TICK         = 2'd0,
		CMD_WRITE_RELOAD = 2'd1,
		CMD_WRITE_STATE  = 2'd2
	} cmd_t;

	// flag byte bit positions
	localparam int unsigned FLAG_STOP    = 0;
	localparam int unsigned FLAG_WRAP    = 1;
	localparam int unsigned FLAG_EXPEN   = 2;
	localparam int unsigned FLAG_ONESHOT = 3;
	localparam int unsigned FLAG_RUN     = 4;
	localparam int unsigned FLAG_PSEL_LO = 5;
	localparam int unsigned FLAG_EXPIRY  = 7;

	localparam logic [CountW-1:0] COUNT_RESET  = 16'hFFFF;
	localparam logic [CountW-1:0] RELOAD_RESET = 16'd4608;
	localparam logic [7:0]        STATUS_HIGH  = 8'hFF;

	typedef struct packed {
		cmd_t              cmd;
		logic [CountW-1:0] data;
	} item_t;

	typedef struct packed {
		logic [CountW-1:0] status;
		logic [CountW-1:0] count;
	} result_t;

	// prescaler firing threshold per select code
	function automatic logic [DivW-1:0] fire_at(input logic [1:0] sel);
		logic [DivW-1:0] t;
		case (sel)
			2'd0:    t = 7'd1;
			2'd1:    t = 7'd16;
			2'd2:    t = 7'd4;
			2'd3:    t = 7'd64;
			default: t = 7'd1;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

>>> hdl/pdt_in_stage.sv
// Input register stage of the prescaled down timer.
// Depends on pdt_pkg.
`default_nettype none

module pdt_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire pdt_pkg::item_t in_item,
	input  wire logic          advance,
	output logic               valid_s1,
	output pdt_pkg::item_t     item_s1
);

	// slot frees when its item moves on this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

>>> hdl/pdt_state.sv
// Timer state registers and the single-pass step logic.
// Depends on pdt_pkg and prescaled_down_timer_core_assert.svh.
`default_nettype none
`include "prescaled_down_timer_core_assert.svh"

module pdt_state (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          advance,
	input  wire pdt_pkg::item_t item_s1,
	output pdt_pkg::result_t   result
);

	logic [pdt_pkg::CountW-1:0] counter_q, counter_d;
	logic [pdt_pkg::CountW-1:0] reload_q, reload_d;
	logic [pdt_pkg::FlagW-1:0]  flags_q, flags_d;
	logic [pdt_pkg::DivW-1:0]   div_q, div_d;

	logic [pdt_pkg::DivW-1:0]   div_inc;
	logic [pdt_pkg::CountW-1:0] cnt_dec;
	logic                       fire;

	assign div_inc = div_q + 7'd1;
	assign fire    = div_inc >= pdt_pkg::fire_at(flags_q[pdt_pkg::FLAG_PSEL_LO +: 2]);
	assign cnt_dec = counter_q - 16'd1;

	always_comb begin
		counter_d = counter_q;
		reload_d  = reload_q;
		flags_d   = flags_q;
		div_d     = div_q;
		case (item_s1.cmd)
			pdt_pkg::CMD_TICK: begin
				if (flags_q[pdt_pkg::FLAG_STOP]) begin
					counter_d = reload_q;
				end else if (flags_q[pdt_pkg::FLAG_RUN]) begin
					if (!fire) begin
						div_d = div_inc;
					end else begin
						div_d     = '0;
						counter_d = cnt_dec;
						if (cnt_dec == '0) begin
							if (!flags_q[pdt_pkg::FLAG_WRAP]) begin
								counter_d = reload_q;
								if (flags_q[pdt_pkg::FLAG_ONESHOT]) begin
									flags_d[pdt_pkg::FLAG_RUN] = 1'b0;
								end
							end
							if (flags_q[pdt_pkg::FLAG_EXPEN]) begin
								flags_d[pdt_pkg::FLAG_EXPIRY] = 1'b1;
							end
						end
					end
				end
			end
			pdt_pkg::CMD_WRITE_RELOAD: begin
				reload_d = item_s1.data;
			end
			pdt_pkg::CMD_WRITE_STATE: begin
				counter_d = reload_q;
				flags_d   = item_s1.data[pdt_pkg::FlagW-1:0];
			end
			default: begin
				// unused code: no change
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= pdt_pkg::COUNT_RESET;
			reload_q  <= pdt_pkg::RELOAD_RESET;
			flags_q   <= '0;
			div_q     <= '0;
		end else if (advance) begin
			counter_q <= counter_d;
			reload_q  <= reload_d;
			flags_q   <= flags_d;
			div_q     <= div_d;
		end
	end

	assign result.count  = counter_d;
	assign result.status = {pdt_pkg::STATUS_HIGH, flags_d};

	// divider is cleared on firing, so it stays below the largest threshold
	`PDT_ASSERT_SAME(a_div_range, clk, arst_n, 1'b1, div_q < 7'd64)
	`PDT_ASSERT_NEXT(a_reload_keeps_count, clk, arst_n,
		advance && item_s1.cmd == pdt_pkg::CMD_WRITE_RELOAD, $stable(counter_q))
	`PDT_ASSERT_NEXT(a_stop_loads, clk, arst_n,
		advance && item_s1.cmd == pdt_pkg::CMD_TICK && flags_q[pdt_pkg::FLAG_STOP],
		counter_q == $past(reload_q) && $stable(div_q))
	`PDT_ASSERT_SAME(a_expiry_sticky, clk, arst_n, $fell(flags_q[pdt_pkg::FLAG_EXPIRY]),
		$past(advance) && $past(item_s1.cmd) == pdt_pkg::CMD_WRITE_STATE)

endmodule

`default_nettype wire

>>> hdl/pdt_out_stage.sv
// Result register of the prescaled down timer.
// Depends on pdt_pkg.
`default_nettype none

module pdt_out_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid_s1,
	input  wire pdt_pkg::result_t result,
	output logic               advance,
	output logic               valid_s2,
	input  wire logic          out_ready,
	output pdt_pkg::result_t   result_s2
);

	logic can_load;

	assign can_load = !valid_s2 || out_ready;
	assign advance  = valid_s1 && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

endmodule

`default_nettype wire

>>> hdl/prescaled_down_timer_core.sv
// Top level of the prescaled down timer: stream ports, input stage, step, result register.
// Depends on pdt_pkg, pdt_in_stage, pdt_state, pdt_out_stage.
//
// Channel  Dir  Signals                       Contents
// s_axis   in   tvalid tready tdata tuser     tdata: data[15:0]; tuser: command[1:0]
// m_axis   out  tvalid tready tdata           tdata: count_value[15:0], status_word[31:16]
//
// One command per clock while the output is not stalled, one result per
// command; the result passes the input register, then the result register,
// before it can transfer out.
// The step is a divider increment and threshold compare, one decrement, a zero
// test and a flag update on the state registers, done between the input register and the result register.
// arst_n clears the state: count 0xFFFF, reload 4608, flags and divider zero.
// A stalled output holds its result; the input stage keeps accepting while
// the result register has room or is being drained in the same cycle.
`default_nettype none

module prescaled_down_timer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] data
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // [15:0] count_value, [31:16] status_word
);

	pdt_pkg::item_t   in_item;
	pdt_pkg::item_t   item_s1;
	pdt_pkg::result_t result;
	pdt_pkg::result_t result_s2;
	logic             valid_s1;
	logic             advance;

	assign in_item.cmd  = pdt_pkg::cmd_t'(s_axis_tuser);
	assign in_item.data = s_axis_tdata;

	pdt_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// state commits on the same edge the result register loads
	pdt_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.result  (result)
	);

	pdt_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.advance   (advance),
		.valid_s2  (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result_s2 (result_s2)
	);

	assign m_axis_tdata = {result_s2.status, result_s2.count};

endmodule

`default_nettype wire

>>> tb/tb_prescaled_down_timer_core.sv
// Self-checking testbench for prescaled_down_timer_core: drives command streams with bursty
// input and a stalling output, and predicts every count/status result in a scoreboard.
// Depends on pdt_pkg and the prescaled_down_timer_core RTL.
`default_nettype none

class timer_scoreboard;
	logic [15:0]        count;
	logic [15:0]        reload;
	logic [7:0]         flags;
	logic [6:0]         divider;
	pdt_pkg::result_t   pending[$];
	int                 errors;
	int                 accepted;
	int                 checked;
	int                 crossings;
	int                 stop_loads;

	function new();
		count      = pdt_pkg::COUNT_RESET;
		reload     = pdt_pkg::RELOAD_RESET;
		flags      = '0;
		divider    = '0;
		errors     = 0;
		accepted   = 0;
		checked    = 0;
		crossings  = 0;
		stop_loads = 0;
	endfunction

	// divider value at which the prescaler fires, per select code
	function logic [6:0] fire_limit(input logic [1:0] sel);
		case (sel)
			2'd1:    return 7'd16;
			2'd2:    return 7'd4;
			2'd3:    return 7'd64;
			default: return 7'd1;
		endcase
	endfunction

	function void advance_tick();
		if (flags[pdt_pkg::FLAG_STOP]) begin
			count = reload;
			stop_loads++;
		end else if (flags[pdt_pkg::FLAG_RUN]) begin
			divider = divider + 7'd1;
			if (divider >= fire_limit(flags[pdt_pkg::FLAG_PSEL_LO +: 2])) begin
				divider = '0;
				count   = count - 16'd1;
				if (count == 16'd0) begin
					crossings++;
					if (!flags[pdt_pkg::FLAG_WRAP]) begin
						if (flags[pdt_pkg::FLAG_ONESHOT])
							flags[pdt_pkg::FLAG_RUN] = 1'b0;
						count = reload;
					end
					if (flags[pdt_pkg::FLAG_EXPEN])
						flags[pdt_pkg::FLAG_EXPIRY] = 1'b1;
				end
			end
		end
	endfunction

	// one accepted command: update the shadow state and queue its result
	function void note_command(input logic [1:0] cmd, input logic [15:0] data);
		pdt_pkg::result_t r;
		case (cmd)
			pdt_pkg::CMD_TICK:         advance_tick();
			pdt_pkg::CMD_WRITE_RELOAD: reload = data;
			pdt_pkg::CMD_WRITE_STATE: begin
				count = reload;
				flags = data[7:0];
			end
			default: ;
		endcase
		r.count  = count;
		r.status = {pdt_pkg::STATUS_HIGH, flags};
		pending.push_back(r);
		accepted++;
	endfunction

	function void check_result(input logic [31:0] tdata);
		pdt_pkg::result_t got;
		pdt_pkg::result_t want;
		got = tdata;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result count=%h status=%h", $time, got.count, got.status);
			errors++;
			return;
		end
		want = pending.pop_front();
		checked++;
		if (got.count !== want.count) begin
			$display("%0t: count_value expected %h actual %h", $time, want.count, got.count);
			errors++;
		end
		if (got.status !== want.status) begin
			$display("%0t: status_word expected %h actual %h", $time, want.status, got.status);
			errors++;
		end
	endfunction
endclass

module tb_prescaled_down_timer_core;

	localparam int          RANDOM_ITEMS = 800;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam logic [1:0]  CMD_UNUSED   = 2'd3;

	// prescale select codes
	localparam logic [1:0]  PSEL_EVERY = 2'd0;
	localparam logic [1:0]  PSEL_BY16  = 2'd1;
	localparam logic [1:0]  PSEL_BY4   = 2'd2;
	localparam logic [1:0]  PSEL_BY64  = 2'd3;

	// flag masks as written through a write-state transfer
	localparam logic [15:0] F_WRAP    = 16'(1) << pdt_pkg::FLAG_WRAP;
	localparam logic [15:0] F_EXPEN   = 16'(1) << pdt_pkg::FLAG_EXPEN;
	localparam logic [15:0] F_ONESHOT = 16'(1) << pdt_pkg::FLAG_ONESHOT;
	localparam logic [15:0] F_RUN     = 16'(1) << pdt_pkg::FLAG_RUN;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;
	logic [1:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	timer_scoreboard sb;
	int cycles      = 0;
	int burst_left  = 0;
	int rx_mode     = 0;
	int rx_left     = 0;
	int rx_phase    = 0;
	int directed_n  = 0;
	bit drained     = 1'b0;

	prescaled_down_timer_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Output side: check each transfer, then pick next ready. The stall
	// pattern switches at random intervals between always-ready, random,
	// a fixed periodic stall and long sticky stretches.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(50, 300);
		end else begin
			rx_left--;
		end
		rx_phase++;
		case (rx_mode)
			0:       m_axis_tready <= 1'b1;
			1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
			2:       m_axis_tready <= ((rx_phase % 3) != 0);
			default: m_axis_tready <= ($urandom_range(0, 15) != 0) ? m_axis_tready : ~m_axis_tready;
		endcase
	end

	// Present one command and hold it until accepted. Gaps are only taken
	// between bursts, so valid stays high through a burst.
	task automatic send_item(input logic [1:0] cmd, input logic [15:0] data);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= data;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_command(cmd, data);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(pdt_pkg::CMD_TICK, 16'($urandom));
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// Typical use: load a reload value, arm the flags, then tick. Reloads
	// are mostly small so zero crossings happen often; flags are random
	// with RUN usually set and STOP rarely.
	task automatic run_sequence();
		logic [15:0] rl;
		logic [15:0] st;
		int          n;
		rl = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
		st = 16'($urandom);
		st[pdt_pkg::FLAG_RUN]  = ($urandom_range(0, 7) != 0);
		st[pdt_pkg::FLAG_STOP] = ($urandom_range(0, 9) == 0);
		send_item(pdt_pkg::CMD_WRITE_RELOAD, rl);
		send_item(pdt_pkg::CMD_WRITE_STATE, st);
		n = $urandom_range(4, 60);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 39))
				0:       send_item(pdt_pkg::CMD_WRITE_RELOAD, 16'($urandom_range(0, 20)));
				1:       send_item(CMD_UNUSED, 16'($urandom));
				2:       send_item(pdt_pkg::CMD_WRITE_STATE, 16'($urandom) | F_RUN);
				default: send_item(pdt_pkg::CMD_TICK, 16'($urandom));
			endcase
		end
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unused code and an idle tick straight out of reset
		send_item(CMD_UNUSED, 16'hFFFF);
		send_item(pdt_pkg::CMD_TICK, 16'h0000);
		// data extremes; all-ones state sets STOP and EXPIRY among the rest
		send_item(pdt_pkg::CMD_WRITE_RELOAD, 16'hFFFF);
		send_item(pdt_pkg::CMD_WRITE_STATE, 16'hFFFF);
		send_item(pdt_pkg::CMD_WRITE_RELOAD, 16'h0000);
		send_item(pdt_pkg::CMD_TICK, 16'hFFFF);     // STOP copies reload
		// one-shot: runs down, reloads, clears RUN, flags expiry
		send_item(pdt_pkg::CMD_WRITE_RELOAD, 16'd3);
		send_item(pdt_pkg::CMD_WRITE_STATE, 16'hA500 | F_RUN | F_EXPEN | F_ONESHOT
			| (16'(PSEL_EVERY) << pdt_pkg::FLAG_PSEL_LO));
		send_ticks(4);
		// wrap: holds at zero after expiring, then rolls to all ones
		send_item(pdt_pkg::CMD_WRITE_RELOAD, 16'd2);
		send_item(pdt_pkg::CMD_WRITE_STATE, F_RUN | F_WRAP | F_EXPEN);
		send_ticks(3);
		// divide by 64, then switch to divide by 4 mid-count: divider is
		// kept and already past the new threshold, so the next tick fires
		send_item(pdt_pkg::CMD_WRITE_STATE, F_RUN | (16'(PSEL_BY64) << pdt_pkg::FLAG_PSEL_LO));
		send_ticks(5);
		send_item(pdt_pkg::CMD_WRITE_STATE, F_RUN | (16'(PSEL_BY4) << pdt_pkg::FLAG_PSEL_LO));
		send_ticks(1);
		send_item(pdt_pkg::CMD_WRITE_STATE, F_RUN | (16'(PSEL_BY16) << pdt_pkg::FLAG_PSEL_LO));
		send_ticks(2);
		directed_n = sb.accepted;

		// random: mostly well-formed sequences, some raw noise
		while (sb.accepted < directed_n + RANDOM_ITEMS) begin
			if (!drained && sb.accepted > directed_n + RANDOM_ITEMS / 2) begin
				drain_results();
				drained = 1'b1;
			end
			if ($urandom_range(0, 9) == 0)
				send_item(2'($urandom), 16'($urandom));
			else
				run_sequence();
		end

		drain_results();
		repeat (10) @(posedge clk);
		$display("tb: %0d commands, %0d results checked, %0d zero crossings, %0d stop reloads",
			sb.accepted, sb.checked, sb.crossings, sb.stop_loads);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
